FILE: src/snnt_pkg.sv
// Shared types, sizes and helpers for the spiking network tick unit.
// Used by snnt_ram users and by spiking_neuron_net_tick_unit; depends on nothing.
package snnt_pkg;

    localparam int NEURONS = 16;
    localparam int FANOUT  = 10;

    localparam int LINKS   = NEURONS * FANOUT;
    localparam int NIDX_W  = $clog2(NEURONS);
    localparam int NCNT_W  = $clog2(NEURONS + 1);
    localparam int LCNT_W  = $clog2(FANOUT + 1);
    localparam int LADDR_W = $clog2(LINKS);

    localparam int FIELD_IDX_W = 4;
    localparam int LEVEL_W     = 16;
    localparam int THR_W       = 15;
    localparam int ACT_W       = 5;
    localparam int MASK_W      = 16;
    localparam int LINK_W      = FIELD_IDX_W + LEVEL_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 1'b1;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd256;
    localparam logic [ACT_W-1:0] ACTIVE_RST    = 5'd16;

    typedef enum logic [1:0] {
        KIND_LINK = 2'd0,
        KIND_STIM = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_INACTIVE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK,
        S_STIM,
        S_SCAN,
        S_HEAD,
        S_SPIKE,
        S_TAIL,
        S_RESULT
    } state_t;

    // Signed 16-bit add that clamps to the representable range.
    function automatic logic signed [LEVEL_W-1:0] sat_add(
        input logic signed [LEVEL_W-1:0] a,
        input logic signed [LEVEL_W-1:0] b
    );
        logic signed [LEVEL_W:0] s;
        s = {a[LEVEL_W-1], a} + {b[LEVEL_W-1], b};
        if (s[LEVEL_W] != s[LEVEL_W-1]) begin
            sat_add = s[LEVEL_W] ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
        end else begin
            sat_add = s[LEVEL_W-1:0];
        end
    endfunction

endpackage

FILE: src/spiking_neuron_net_tick_unit.sv
// Spiking network tick unit: link add, neuron stimulus and two-phase tick sequencer.
// Depends on snnt_pkg and snnt_ram.
// Add link and stimulate run their own state, then S_RESULT; an unused kind only S_RESULT.
// A tick scans the neurons in use, then visits each in S_HEAD, a fired one also in S_SPIKE
// per link and S_TAIL; one level adder and one link read port visit one step a cycle.
// One item is in work at a time; the input is not ready until its result is registered.
// Synchronous active-low reset clears levels and link counts, loads the register defaults.
module spiking_neuron_net_tick_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [3:0] source_neuron, [7:4] target_neuron, [23:8] amount
    input  logic [23:0]                         s_tdata,
    // [1:0] kind
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [17:2] fired_mask, [23:18] zero
    output logic [23:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [snnt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [snnt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import snnt_pkg::*;

    // Configuration registers; writes are only expected while no item is in work.
    logic [THR_W-1:0] threshold_reg;
    logic [ACT_W-1:0] active_reg;

    // Neuron state. Levels are read through one muxed port that feeds the shared adder.
    logic signed [LEVEL_W-1:0] level_reg [NEURONS];
    logic [LCNT_W-1:0]         lcount_reg [NEURONS];

    // Captured item fields.
    logic [FIELD_IDX_W-1:0]    src_reg;
    logic [FIELD_IDX_W-1:0]    dst_reg;
    logic signed [LEVEL_W-1:0] amount_reg;

    // Sequencer registers.
    state_t               state_reg, state_next;
    logic [NCNT_W-1:0]    idx_reg, idx_next;
    logic [LCNT_W-1:0]    k_reg, k_next;
    logic [NEURONS-1:0]   fired_reg, fired_next;
    status_t              status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [MASK_W-1:0]    m_mask_reg, m_mask_next;

    // Write strobes into the neuron state.
    logic                      lvl_we;
    logic [NIDX_W-1:0]         lvl_widx;
    logic signed [LEVEL_W-1:0] lvl_wdata;
    logic                      cnt_we;
    logic [NIDX_W-1:0]         cnt_widx;

    // Shared adder and compare operands.
    logic [NIDX_W-1:0]         rd_idx;
    logic signed [LEVEL_W-1:0] rd_level;
    logic signed [LEVEL_W-1:0] add_b;
    logic signed [LEVEL_W-1:0] add_sum;
    logic                      at_threshold;

    // Link memory: target in the low bits, weight above it.
    logic                      ram_we;
    logic [LADDR_W-1:0]        ram_waddr;
    logic [LINK_W-1:0]         ram_wdata;
    logic [LADDR_W-1:0]        ram_raddr;
    logic [LINK_W-1:0]         ram_rdata;
    logic [FIELD_IDX_W-1:0]    link_target;
    logic signed [LEVEL_W-1:0] link_weight;

    logic [NCNT_W-1:0]  n_use;
    logic [NIDX_W-1:0]  idx_n;
    logic [NIDX_W-1:0]  src_n;
    logic [LADDR_W-1:0] visit_base;
    logic               src_ok;
    logic               dst_ok;
    logic               idx_live;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, m_mask_reg, m_status_reg};

    assign link_target = ram_rdata[FIELD_IDX_W-1:0];
    assign link_weight = ram_rdata[LINK_W-1:FIELD_IDX_W];

    // A register value above the neuron count acts as the full network.
    always_comb begin
        if (int'(active_reg) > NEURONS) begin
            n_use = NCNT_W'(NEURONS);
        end else begin
            n_use = NCNT_W'(active_reg);
        end
    end

    assign idx_n    = idx_reg[NIDX_W-1:0];
    assign src_n    = NIDX_W'(src_reg);
    assign src_ok   = int'(src_reg) < int'(n_use);
    assign dst_ok   = int'(dst_reg) < int'(n_use);
    assign idx_live = idx_reg < n_use;

    assign visit_base = LADDR_W'(idx_n) * LADDR_W'(FANOUT);

    // The level is signed, so it is sign-extended before the compare against the threshold.
    assign rd_level     = level_reg[rd_idx];
    assign add_sum      = sat_add(rd_level, add_b);
    assign at_threshold = $signed({rd_level[LEVEL_W-1], rd_level}) >=
                          $signed({2'b00, threshold_reg});

    snnt_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINKS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: next state, datapath selects and write strobes.
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        fired_next    = fired_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_mask_next   = m_mask_reg;

        rd_idx    = src_n;
        add_b     = amount_reg;
        lvl_we    = 1'b0;
        lvl_widx  = src_n;
        lvl_wdata = add_sum;
        cnt_we    = 1'b0;
        cnt_widx  = src_n;
        ram_we    = 1'b0;
        ram_waddr = LADDR_W'(src_n) * LADDR_W'(FANOUT) + LADDR_W'(lcount_reg[src_n]);
        ram_wdata = {amount_reg, dst_reg};
        ram_raddr = visit_base;

        // The result register empties as soon as the consumer takes it.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    idx_next    = '0;
                    fired_next  = '0;
                    status_next = STAT_OK;
                    case (s_tuser)
                        KIND_LINK: state_next = S_LINK;
                        KIND_STIM: state_next = S_STIM;
                        KIND_TICK: state_next = S_SCAN;
                        default:   state_next = S_RESULT;
                    endcase
                end
            end
            S_LINK: begin
                if (!src_ok || !dst_ok) begin
                    status_next = STAT_INACTIVE;
                end else if (int'(lcount_reg[src_n]) >= FANOUT) begin
                    status_next = STAT_FULL;
                end else begin
                    ram_we = 1'b1;
                    cnt_we = 1'b1;
                end
                state_next = S_RESULT;
            end
            S_STIM: begin
                if (src_ok) begin
                    lvl_we = 1'b1;
                end else begin
                    status_next = STAT_INACTIVE;
                end
                state_next = S_RESULT;
            end
            S_SCAN: begin
                // First phase: mark every neuron in use that reaches the threshold.
                rd_idx = idx_n;
                if (idx_live) begin
                    if (at_threshold) begin
                        fired_next[idx_n] = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end else begin
                    idx_next   = '0;
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                // Second phase: visit neurons in index order.
                k_next = LCNT_W'(1);
                if (!idx_live) begin
                    state_next = S_RESULT;
                end else if (fired_reg[idx_n]) begin
                    if (lcount_reg[idx_n] == '0) begin
                        state_next = S_TAIL;
                    end else begin
                        state_next = S_SPIKE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SPIKE: begin
                // The link whose read was issued in the cycle before is now on the memory output.
                rd_idx    = NIDX_W'(link_target);
                add_b     = link_weight;
                lvl_we    = 1'b1;
                lvl_widx  = NIDX_W'(link_target);
                ram_raddr = visit_base + LADDR_W'(k_reg);
                if (k_reg < lcount_reg[idx_n]) begin
                    k_next = k_reg + 1'b1;
                end else begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                lvl_we     = 1'b1;
                lvl_widx   = idx_n;
                lvl_wdata  = '0;
                idx_next   = idx_reg + 1'b1;
                state_next = S_HEAD;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_mask_next   = MASK_W'(fired_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        fired_reg    <= fired_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_mask_reg   <= m_mask_next;
        if (s_tvalid && s_tready) begin
            src_reg    <= s_tdata[3:0];
            dst_reg    <= s_tdata[7:4];
            amount_reg <= s_tdata[23:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            active_reg    <= ACTIVE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                CFG_ACTIVE:    active_reg    <= cfg_data[ACT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Neuron levels and link counts start from zero after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NEURONS; i++) begin
                level_reg[i]  <= '0;
                lcount_reg[i] <= '0;
            end
        end else begin
            if (lvl_we) begin
                level_reg[lvl_widx] <= lvl_wdata;
            end
            if (cnt_we) begin
                lcount_reg[cnt_widx] <= lcount_reg[cnt_widx] + 1'b1;
            end
        end
    end

endmodule

FILE: src/snnt_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing; holds the link table of the tick unit.
module snnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
